// ===== design/bbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbrs_pkg
// Shared types and constants for the bouncing ball rhythm sequencer.
// ----------------------------------------------------------------------------
package bbrs_pkg;

    localparam int COLUMNS = 8;

    // input item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_PAD   = 2'd2;
    localparam logic [1:0] MODE_SCENE = 2'd3;

    localparam logic [2:0] ROW_EMPTY  = 3'd7;
    localparam logic [6:0] MAX_DIVIDE = 7'd64;
    localparam logic [6:0] MIN_DIVIDE = 7'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] button_index;
    } bbrs_in_t;

    typedef struct packed {
        logic [7:0] trigger_mask;
        logic [7:0] active_mask;
        logic [7:0] mute_mask;
    } bbrs_out_t;

    // per-column command for one processed item
    typedef struct packed {
        logic       step;
        logic       clear_phase;
        logic       load;
        logic [2:0] height;
        logic       toggle_mute;
    } bbrs_col_cmd_t;

    // per-column status after the item
    typedef struct packed {
        logic trigger;
        logic active;
        logic muted;
    } bbrs_col_stat_t;

endpackage

// ===== design/bbrs_divider.sv =====
// ----------------------------------------------------------------------------
// bbrs_divider
// Divide-by-N tick counter; fires on the tick that completes a division.
// ----------------------------------------------------------------------------
module bbrs_divider (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tick,
    input  logic       clear,
    input  logic [6:0] clock_divide,
    output logic       fire
);

    logic [5:0] count_reg;
    logic [5:0] count_next;
    logic [6:0] divide_eff;
    logic [6:0] count_inc;

    always_comb begin
        divide_eff = clock_divide;
        if (clock_divide < bbrs_pkg::MIN_DIVIDE) begin
            divide_eff = bbrs_pkg::MIN_DIVIDE;
        end else if (clock_divide > bbrs_pkg::MAX_DIVIDE) begin
            divide_eff = bbrs_pkg::MAX_DIVIDE;
        end
    end

    always_comb begin
        count_inc  = {1'b0, count_reg} + 7'd1;
        count_next = count_reg;
        fire       = 1'b0;
        if (clear) begin
            count_next = '0;
        end else if (tick) begin
            // compare after increment so a lowered divide restarts at once
            if (count_inc >= divide_eff) begin
                count_next = '0;
                fire       = 1'b1;
            end else begin
                count_next = count_inc[5:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/bbrs_column.sv =====
// ----------------------------------------------------------------------------
// bbrs_column
// One column: ball height, phase counter modulo twice the height, mute flag.
// ----------------------------------------------------------------------------
module bbrs_column (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bbrs_pkg::bbrs_col_cmd_t  cmd,
    output bbrs_pkg::bbrs_col_stat_t stat
);

    logic [2:0] height_reg;
    logic [2:0] height_next;
    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic       muted_reg;
    logic       muted_next;
    logic [3:0] phase_inc;
    logic       trigger;

    always_comb begin
        height_next = height_reg;
        phase_next  = phase_reg;
        muted_next  = muted_reg;
        trigger     = 1'b0;
        phase_inc   = phase_reg + 4'd1;

        if (cmd.step && (height_reg != 3'd0)) begin
            // wrap at twice the height
            if (phase_inc == {height_reg, 1'b0}) begin
                phase_next = '0;
            end else begin
                phase_next = phase_inc;
            end
            trigger = (phase_next == {1'b0, height_reg}) && !muted_reg;
        end
        if (cmd.clear_phase) begin
            phase_next = '0;
        end
        if (cmd.load) begin
            height_next = cmd.height;
            phase_next  = '0;
        end
        if (cmd.toggle_mute) begin
            muted_next = !muted_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= '0;
            phase_reg  <= '0;
            muted_reg  <= 1'b0;
        end else begin
            height_reg <= height_next;
            phase_reg  <= phase_next;
            muted_reg  <= muted_next;
        end
    end

    assign stat.trigger = trigger;
    assign stat.active  = (height_next != 3'd0);
    assign stat.muted   = muted_next;

endmodule

// ===== design/bouncing_ball_rhythm_sequencer.sv =====
// ----------------------------------------------------------------------------
// bouncing_ball_rhythm_sequencer
// Eight-column bouncing ball sequencer: clock ticks, phase reset, pad and
// scene presses in; trigger, active and mute masks out, one per item.
// ----------------------------------------------------------------------------
//   channel  | ports                    | payload
//   ---------+--------------------------+-------------------------------------
//   input    | s_valid s_ready s_data   | mode, button_index
//   result   | m_valid m_ready m_data   | trigger_mask, active_mask, mute_mask
//   config   | cfg_we cfg_wdata         | clock_divide
//
// One item per cycle sustained while the result side accepts; an input transfer passes
// the input register, then the column update into the result register.
// The eight column counters and the divider update in parallel in that stage.
// Synchronous active-low reset clears all balls, mutes, the divider count and
// sets clock_divide to 1. A stalled result holds the update stage; the input
// register still takes one item while the result waits.
// ----------------------------------------------------------------------------
module bouncing_ball_rhythm_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bbrs_pkg::bbrs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bbrs_pkg::bbrs_out_t m_data,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata
);

    logic [6:0]          divide_reg;
    bbrs_pkg::bbrs_in_t  in_item_reg;
    logic                in_valid_reg;
    bbrs_pkg::bbrs_out_t out_data_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                do_item;
    logic                fire;
    logic [2:0]          row;
    logic [2:0]          col;
    logic [2:0]          pad_height;

    bbrs_pkg::bbrs_col_cmd_t  col_cmd  [bbrs_pkg::COLUMNS];
    bbrs_pkg::bbrs_col_stat_t col_stat [bbrs_pkg::COLUMNS];
    bbrs_pkg::bbrs_out_t      out_next;

    assign advance = !out_valid_reg || m_ready;
    assign do_item = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divide_reg <= 7'd1;
        end else if (cfg_we) begin
            divide_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    bbrs_divider u_divider (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (do_item && (in_item_reg.mode == bbrs_pkg::MODE_TICK)),
        .clear        (do_item && (in_item_reg.mode == bbrs_pkg::MODE_RESET)),
        .clock_divide (divide_reg),
        .fire         (fire)
    );

    assign row = in_item_reg.button_index[5:3];
    assign col = in_item_reg.button_index[2:0];
    // row 7 removes the ball
    assign pad_height = (row < bbrs_pkg::ROW_EMPTY) ? (bbrs_pkg::ROW_EMPTY - row) : 3'd0;

    for (genvar c = 0; c < bbrs_pkg::COLUMNS; c++) begin : g_col
        always_comb begin
            col_cmd[c].step        = fire;
            col_cmd[c].clear_phase = do_item && (in_item_reg.mode == bbrs_pkg::MODE_RESET);
            col_cmd[c].load        = do_item && (in_item_reg.mode == bbrs_pkg::MODE_PAD)
                                     && (col == 3'(c));
            col_cmd[c].height      = pad_height;
            col_cmd[c].toggle_mute = do_item && (in_item_reg.mode == bbrs_pkg::MODE_SCENE)
                                     && (col == 3'(c));
        end

        bbrs_column u_column (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (col_cmd[c]),
            .stat    (col_stat[c])
        );

        assign out_next.trigger_mask[c] = col_stat[c].trigger;
        assign out_next.active_mask[c]  = col_stat[c].active;
        assign out_next.mute_mask[c]    = col_stat[c].muted;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_item) begin
            out_data_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/bbrs_checker.sv =====
// ----------------------------------------------------------------------------
// bbrs_checker
// Port-level checks for the bouncing ball rhythm sequencer.
// ----------------------------------------------------------------------------
module bbrs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bbrs_pkg::bbrs_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input bbrs_pkg::bbrs_out_t m_data,
    input logic                cfg_we,
    input logic [6:0]          cfg_wdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // only a column holding a ball can fire
    a_trig_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.trigger_mask & ~m_data.active_mask) == 8'd0))
        else $error("trigger on empty column");

    // a muted column never fires
    a_trig_mute: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.trigger_mask & m_data.mute_mask) == 8'd0))
        else $error("trigger on muted column");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bouncing_ball_rhythm_sequencer bbrs_checker u_bbrs_checker (.*);

// ===== verif/bbrs_result_checker.sv =====
// ----------------------------------------------------------------------------
// bbrs_result_checker
// Watches the input, result and configuration ports of the bouncing ball
// sequencer, keeps its own copy of the column state, predicts the masks for
// every input transfer and compares each result transfer against the oldest
// prediction. Mismatch and pending counts go back to the testbench top.
// ----------------------------------------------------------------------------
module bbrs_result_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bbrs_pkg::bbrs_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bbrs_pkg::bbrs_out_t m_data,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [2:0]          heights [bbrs_pkg::COLUMNS];
    logic [3:0]          phases  [bbrs_pkg::COLUMNS];
    logic                muted   [bbrs_pkg::COLUMNS];
    logic [5:0]          step_count;
    logic [6:0]          divide_setting;
    bbrs_pkg::bbrs_out_t expected_masks [$];
    bbrs_pkg::bbrs_out_t want;

    function automatic void clear_columns();
        for (int c = 0; c < bbrs_pkg::COLUMNS; c++) begin
            heights[c] = 3'd0;
            phases[c]  = 4'd0;
            muted[c]   = 1'b0;
        end
        step_count     = 6'd0;
        divide_setting = bbrs_pkg::MIN_DIVIDE;
    endfunction

    // Update the column state for one event and return the masks it yields.
    function automatic bbrs_pkg::bbrs_out_t apply_event(input bbrs_pkg::bbrs_in_t ev);
        bbrs_pkg::bbrs_out_t res;
        logic [2:0]          col;
        logic [2:0]          row;
        int                  divide;
        int                  next_phase;
        res = '0;
        col = ev.button_index[2:0];
        row = ev.button_index[5:3];
        case (ev.mode)
            bbrs_pkg::MODE_TICK: begin
                divide = int'(divide_setting);
                if (divide < int'(bbrs_pkg::MIN_DIVIDE)) divide = int'(bbrs_pkg::MIN_DIVIDE);
                if (divide > int'(bbrs_pkg::MAX_DIVIDE)) divide = int'(bbrs_pkg::MAX_DIVIDE);
                // increment, then compare: a count above a lowered divide fires at once
                if (int'(step_count) + 1 >= divide) begin
                    step_count = 6'd0;
                    for (int c = 0; c < bbrs_pkg::COLUMNS; c++) begin
                        if (heights[c] != 3'd0) begin
                            next_phase = (int'(phases[c]) + 1) % (2 * int'(heights[c]));
                            phases[c]  = next_phase[3:0];
                            if (next_phase == int'(heights[c]) && !muted[c])
                                res.trigger_mask[c] = 1'b1;
                        end
                    end
                end else begin
                    step_count = step_count + 6'd1;
                end
            end
            bbrs_pkg::MODE_RESET: begin
                for (int c = 0; c < bbrs_pkg::COLUMNS; c++)
                    phases[c] = 4'd0;
                step_count = 6'd0;
            end
            bbrs_pkg::MODE_PAD: begin
                if (row < bbrs_pkg::ROW_EMPTY)
                    heights[col] = bbrs_pkg::ROW_EMPTY - row;
                else
                    heights[col] = 3'd0;
                phases[col] = 4'd0;
            end
            bbrs_pkg::MODE_SCENE: begin
                muted[col] = !muted[col];
            end
            default: begin
            end
        endcase
        for (int c = 0; c < bbrs_pkg::COLUMNS; c++) begin
            res.active_mask[c] = (heights[c] != 3'd0);
            res.mute_mask[c]   = muted[c];
        end
        return res;
    endfunction

    function automatic void note_mismatch(input string what,
                                          input bbrs_pkg::bbrs_out_t exp_val,
                                          input bbrs_pkg::bbrs_out_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display({"%0t: %s: expected trig %02h act %02h mute %02h, ",
                      "got trig %02h act %02h mute %02h"},
                     $time, what, exp_val.trigger_mask, exp_val.active_mask,
                     exp_val.mute_mask, got.trigger_mask, got.active_mask, got.mute_mask);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_columns();
            expected_masks.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (s_valid && s_ready)
                expected_masks.push_back(apply_event(s_data));
            if (m_valid && m_ready) begin
                if (expected_masks.size() == 0) begin
                    note_mismatch("result transfer with nothing pending", '0, m_data);
                end else begin
                    want = expected_masks.pop_front();
                    if (m_data.trigger_mask !== want.trigger_mask ||
                        m_data.active_mask  !== want.active_mask  ||
                        m_data.mute_mask    !== want.mute_mask)
                        note_mismatch("mask mismatch", want, m_data);
                end
            end
            // the bench must write only while idle (not enforced here), so order against transfers does not matter
            if (cfg_we)
                divide_setting = cfg_wdata;
            pending = expected_masks.size();
        end
    end

endmodule

// ===== verif/tb_bouncing_ball_rhythm_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_bouncing_ball_rhythm_sequencer
// Drives pad, scene, tick and phase-reset events into the sequencer under a
// range of clock divide settings, with random gaps and stalls on both
// channels, a long result hold-off and a full drain. The checker alongside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bouncing_ball_rhythm_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RECEIVER_HOLD    = 200;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int PHASES           = 10;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    bbrs_pkg::bbrs_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    bbrs_pkg::bbrs_out_t m_data;
    logic                cfg_we;
    logic [6:0]          cfg_wdata;

    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    bit         steady;
    bit         hold_results;
    logic [6:0] divide_plan [PHASES];

    bouncing_ball_rhythm_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bbrs_result_checker u_result_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bouncing_ball_rhythm_sequencer test failed");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_ready_gen
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (RECEIVER_HOLD) @(negedge aclk);
                hold_results = 1'b0;
                stall        = 0;
                m_ready <= 1'b1;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!steady) stall = idle_gap();
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [5:0] index);
        bbrs_pkg::bbrs_in_t item;
        int                 gap;
        item.mode         = op;
        item.button_index = index;
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random();
        int         roll;
        logic [1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 55)      op = bbrs_pkg::MODE_TICK;
        else if (roll < 63) op = bbrs_pkg::MODE_RESET;
        else if (roll < 88) op = bbrs_pkg::MODE_PAD;
        else                op = bbrs_pkg::MODE_SCENE;
        send_item(op, 6'($urandom_range(0, 63)));
    endtask

    // hold the input until every pending result has come back
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_divide(input logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        steady       = 1'b0;
        hold_results = 1'b0;
        divide_plan  = '{7'd0, 7'd2, 7'd127, 7'd1, 7'd5, 7'd65, 7'd3, 7'd64, 7'd1, 7'd0};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_divide(bbrs_pkg::MIN_DIVIDE);
        // one ball per height, column c gets height c + 1
        for (int c = 0; c < 7; c++)
            send_item(bbrs_pkg::MODE_PAD, 6'((6 - c) * 8 + c));
        send_item(bbrs_pkg::MODE_PAD, 6'd63);       // remove from an empty column
        send_item(bbrs_pkg::MODE_SCENE, 6'd63);     // upper index bits ignored
        send_item(bbrs_pkg::MODE_SCENE, 6'd1);
        repeat (7) send_item(bbrs_pkg::MODE_TICK, 6'd0);
        send_item(bbrs_pkg::MODE_RESET, 6'd63);
        repeat (3) send_item(bbrs_pkg::MODE_TICK, 6'd0);
        send_item(bbrs_pkg::MODE_PAD, 6'd56);       // remove the ball in column 0
        send_item(bbrs_pkg::MODE_SCENE, 6'd9);
        send_item(bbrs_pkg::MODE_TICK, 6'd63);
        send_item(bbrs_pkg::MODE_TICK, 6'd0);
        drain_results(4);

        // leave the count high, then lower the divide below it
        write_divide(bbrs_pkg::MAX_DIVIDE);
        repeat (50) send_item(bbrs_pkg::MODE_TICK, 6'($urandom_range(0, 63)));
        drain_results(4);
        write_divide(7'd3);
        repeat (6) send_item(bbrs_pkg::MODE_TICK, 6'd0);

        for (int p = 0; p < PHASES; p++) begin
            drain_results(4);
            if (p == PHASES - 1)
                write_divide(7'($urandom_range(1, 64)));
            else
                write_divide(divide_plan[p]);
            steady = (p == 3 || p == 6);
            if (p == 4) begin
                // keep offering while results are held off, so the input backs up
                steady       = 1'b1;
                hold_results = 1'b1;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == 2 && n == RANDOM_PER_PHASE / 2)
                    drain_results(0);
                send_random();
            end
        end
        steady = 1'b0;
        drain_results(8);

        if (fail_count == 0 && pending == 0)
            $display("bouncing_ball_rhythm_sequencer test passed");
        else
            $display("bouncing_ball_rhythm_sequencer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bbrs_pkg.sv
design/bbrs_divider.sv
design/bbrs_column.sv
design/bouncing_ball_rhythm_sequencer.sv
design/bbrs_checker.sv
verif/bbrs_result_checker.sv
verif/tb_bouncing_ball_rhythm_sequencer.sv
